### src/axsd_pkg.sv
`default_nettype none
package axsd_pkg;

    localparam int AES_ROUNDS = 10;
    localparam int MAX_SECTOR_BLOCKS = 4096;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 64;
    localparam int BPS_W = 13;
    localparam int BIS_W = 12;
    localparam int ROUND_W = 4;

    localparam logic [CFG_IDX_W-1:0] REG_DATA_KEY_HIGH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DATA_KEY_LOW = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TWEAK_KEY_HIGH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TWEAK_KEY_LOW = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_START_SECTOR_HIGH = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_START_SECTOR_LOW = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCKS_PER_SECTOR = 3'd6;

    typedef struct packed {
        logic        restart;
        logic [63:0] cipher_high;
        logic [63:0] cipher_low;
    } in_item_t;

    typedef struct packed {
        logic [63:0] plain_high;
        logic [63:0] plain_low;
    } out_item_t;

    typedef struct packed {
        logic load_block;
        logic dkey_init;
        logic dkey_step;
        logic tweak_init;
        logic tweak_round;
        logic data_init;
        logic data_round;
        logic finish;
    } axsd_cmd_t;

    typedef struct packed {
        logic need_dkey;
        logic need_tweak;
    } axsd_stat_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] RCON [10] = '{
        8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
    };

    function automatic logic [7:0] inv_sbox(input logic [7:0] v);
        logic [7:0] r;
        r = 8'h00;
        for (int i = 0; i < 256; i++)
        begin
            if (SBOX[i] == v)
            begin
                r = i[7:0];
            end
        end
        return r;
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // one AES-128 key schedule step: round key r-1 -> round key r
    function automatic logic [127:0] key_step(input logic [127:0] k, input logic [3:0] r);
        logic [31:0] t;
        logic [31:0] w0, w1, w2, w3;
        t = {SBOX[k[23:16]] ^ RCON[r - 4'd1], SBOX[k[15:8]], SBOX[k[7:0]], SBOX[k[31:24]]};
        w0 = k[127:96] ^ t;
        w1 = k[95:64] ^ w0;
        w2 = k[63:32] ^ w1;
        w3 = k[31:0] ^ w2;
        return {w0, w1, w2, w3};
    endfunction

    // inverse step: round key r -> round key r-1
    function automatic logic [127:0] key_unstep(input logic [127:0] k, input logic [3:0] r);
        logic [31:0] t;
        logic [31:0] w0, w1, w2, w3;
        w3 = k[31:0] ^ k[63:32];
        w2 = k[63:32] ^ k[95:64];
        w1 = k[95:64] ^ k[127:96];
        t = {SBOX[w3[23:16]] ^ RCON[r - 4'd1], SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
        w0 = k[127:96] ^ t;
        return {w0, w1, w2, w3};
    endfunction

    function automatic logic [7:0] byte_of(input logic [127:0] s, input int i);
        return s[127 - 8*i -: 8];
    endfunction

    function automatic logic [127:0] enc_round(input logic [127:0] s, input logic last);
        logic [7:0] t [16];
        logic [127:0] o;
        logic [7:0] a0, a1, a2, a3, al;
        for (int c = 0; c < 4; c++)
        begin
            for (int i = 0; i < 4; i++)
            begin
                t[i + 4*c] = SBOX[byte_of(s, i + 4*((c + i) & 3))];
            end
        end
        for (int c = 0; c < 4; c++)
        begin
            a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
            al = a0 ^ a1 ^ a2 ^ a3;
            if (!last)
            begin
                t[4*c]   = a0 ^ al ^ xtime(a0 ^ a1);
                t[4*c+1] = a1 ^ al ^ xtime(a1 ^ a2);
                t[4*c+2] = a2 ^ al ^ xtime(a2 ^ a3);
                t[4*c+3] = a3 ^ al ^ xtime(a3 ^ a0);
            end
        end
        for (int i = 0; i < 16; i++)
        begin
            o[127 - 8*i -: 8] = t[i];
        end
        return o;
    endfunction

    function automatic logic [127:0] inv_shift_sub(input logic [127:0] s);
        logic [127:0] o;
        for (int c = 0; c < 4; c++)
        begin
            for (int i = 0; i < 4; i++)
            begin
                o[127 - 8*(i + 4*c) -: 8] = inv_sbox(byte_of(s, i + 4*((c - i + 4) & 3)));
            end
        end
        return o;
    endfunction

    function automatic logic [127:0] inv_mix(input logic [127:0] s);
        logic [127:0] o;
        logic [7:0] a [4];
        logic [7:0] x2 [4];
        logic [7:0] x4 [4];
        logic [7:0] x8 [4];
        logic [7:0] m9 [4];
        logic [7:0] mb [4];
        logic [7:0] md [4];
        logic [7:0] me [4];
        for (int c = 0; c < 4; c++)
        begin
            for (int i = 0; i < 4; i++)
            begin
                a[i] = byte_of(s, 4*c + i);
                x2[i] = xtime(a[i]);
                x4[i] = xtime(x2[i]);
                x8[i] = xtime(x4[i]);
                m9[i] = x8[i] ^ a[i];
                mb[i] = x8[i] ^ x2[i] ^ a[i];
                md[i] = x8[i] ^ x4[i] ^ a[i];
                me[i] = x8[i] ^ x4[i] ^ x2[i];
            end
            o[127 - 8*(4*c)   -: 8] = me[0] ^ mb[1] ^ md[2] ^ m9[3];
            o[127 - 8*(4*c+1) -: 8] = m9[0] ^ me[1] ^ mb[2] ^ md[3];
            o[127 - 8*(4*c+2) -: 8] = md[0] ^ m9[1] ^ me[2] ^ mb[3];
            o[127 - 8*(4*c+3) -: 8] = mb[0] ^ md[1] ^ m9[2] ^ me[3];
        end
        return o;
    endfunction

    function automatic logic [127:0] gf_double(input logic [127:0] t);
        logic [7:0] b [16];
        logic [7:0] o [16];
        logic [127:0] r;
        for (int i = 0; i < 16; i++)
        begin
            b[i] = byte_of(t, i);
        end
        for (int i = 1; i < 16; i++)
        begin
            o[i] = {b[i][6:0], b[i-1][7]};
        end
        o[0] = {b[0][6:0], 1'b0} ^ (b[15][7] ? 8'h87 : 8'h00);
        for (int i = 0; i < 16; i++)
        begin
            r[127 - 8*i -: 8] = o[i];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

### src/axsd_ctrl.sv
`default_nettype none
module axsd_ctrl
(
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire                    out_ready,
    input  axsd_pkg::axsd_stat_t   stat,
    output axsd_pkg::axsd_cmd_t    cmd
);
    import axsd_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_TWEAK = 3'd1;
    localparam logic [2:0] ST_DINIT = 3'd2;
    localparam logic [2:0] ST_DATA = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;
    localparam logic [2:0] ST_DKEY = 3'd5;

    logic [2:0]         state_reg, state_next;
    logic [ROUND_W-1:0] round_reg, round_next;
    logic               out_valid_reg, out_valid_next;

    assign in_ready = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        round_next = round_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd.load_block = 1'b1;
                    state_next = stat.need_dkey ? ST_DKEY : ST_TWEAK;
                end
            end
            ST_DKEY:
            begin
                if (round_reg == '0)
                begin
                    cmd.dkey_init = 1'b1;
                    round_next = 4'd1;
                end
                else
                begin
                    cmd.dkey_step = 1'b1;
                    if (round_reg == AES_ROUNDS[ROUND_W-1:0])
                    begin
                        round_next = '0;
                        state_next = ST_TWEAK;
                    end
                    else
                    begin
                        round_next = round_reg + 4'd1;
                    end
                end
            end
            ST_TWEAK:
            begin
                if (!stat.need_tweak)
                begin
                    state_next = ST_DINIT;
                end
                else if (round_reg == '0)
                begin
                    cmd.tweak_init = 1'b1;
                    round_next = 4'd1;
                end
                else
                begin
                    cmd.tweak_round = 1'b1;
                    if (round_reg == AES_ROUNDS[ROUND_W-1:0])
                    begin
                        round_next = '0;
                        state_next = ST_DINIT;
                    end
                    else
                    begin
                        round_next = round_reg + 4'd1;
                    end
                end
            end
            ST_DINIT:
            begin
                cmd.data_init = 1'b1;
                round_next = 4'd1;
                state_next = ST_DATA;
            end
            ST_DATA:
            begin
                cmd.data_round = 1'b1;
                if (round_reg == AES_ROUNDS[ROUND_W-1:0])
                begin
                    round_next = '0;
                    state_next = ST_DONE;
                end
                else
                begin
                    round_next = round_reg + 4'd1;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.finish = 1'b1;
                    out_valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            round_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            round_reg <= round_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

### src/axsd_dp.sv
`default_nettype none
module axsd_dp
(
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              cfg_we,
    input  wire [axsd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire [axsd_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  axsd_pkg::in_item_t               in_item,
    input  axsd_pkg::axsd_cmd_t              cmd,
    output axsd_pkg::axsd_stat_t             stat,
    output axsd_pkg::out_item_t              out_item
);
    import axsd_pkg::*;

    logic [127:0]       dkey_reg, tkey_reg, start_reg;
    logic [BPS_W-1:0]   bps_reg;
    logic [127:0]       dkey_last_reg;
    logic               dk_ok_reg;
    logic [127:0]       sector_reg, sector_next;
    logic [BIS_W-1:0]   bis_reg;
    logic [127:0]       tweak_reg;
    logic [127:0]       cipher_reg;
    logic [127:0]       st_reg;
    logic [127:0]       rk_reg;
    logic [ROUND_W-1:0] rnd_reg;
    logic [127:0]       plain_reg;
    logic [BPS_W-1:0]   n_eff;
    logic [127:0]       dec_tmp;

    assign stat.need_tweak = (bis_reg == '0);
    assign stat.need_dkey = !dk_ok_reg;
    assign out_item = plain_reg;

    always_comb
    begin
        if (bps_reg == '0)
        begin
            n_eff = 13'd1;
        end
        else if (bps_reg > MAX_SECTOR_BLOCKS[BPS_W-1:0])
        begin
            n_eff = MAX_SECTOR_BLOCKS[BPS_W-1:0];
        end
        else
        begin
            n_eff = bps_reg;
        end
        sector_next = sector_reg + 128'd1;
        dec_tmp = inv_shift_sub(st_reg) ^ rk_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dkey_reg <= '0;
            tkey_reg <= '0;
            start_reg <= '0;
            bps_reg <= 13'd32;
            dk_ok_reg <= 1'b0;
            sector_reg <= '0;
            bis_reg <= '0;
            tweak_reg <= '0;
        end
        else
        begin
            if (cmd.dkey_step && rnd_reg == AES_ROUNDS[ROUND_W-1:0])
            begin
                dk_ok_reg <= 1'b1;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_DATA_KEY_HIGH:
                    begin
                        dkey_reg[127:64] <= cfg_data;
                        dk_ok_reg <= 1'b0;
                    end
                    REG_DATA_KEY_LOW:
                    begin
                        dkey_reg[63:0] <= cfg_data;
                        dk_ok_reg <= 1'b0;
                    end
                    REG_TWEAK_KEY_HIGH:    tkey_reg[127:64] <= cfg_data;
                    REG_TWEAK_KEY_LOW:     tkey_reg[63:0] <= cfg_data;
                    REG_START_SECTOR_HIGH: start_reg[127:64] <= cfg_data;
                    REG_START_SECTOR_LOW:  start_reg[63:0] <= cfg_data;
                    REG_BLOCKS_PER_SECTOR: bps_reg <= cfg_data[BPS_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.load_block && in_item.restart)
            begin
                sector_reg <= start_reg;
                bis_reg <= '0;
            end
            if (cmd.tweak_round && rnd_reg == AES_ROUNDS[ROUND_W-1:0])
            begin
                tweak_reg <= enc_round(st_reg, 1'b1) ^ key_step(rk_reg, rnd_reg);
            end
            if (cmd.finish)
            begin
                tweak_reg <= gf_double(tweak_reg);
                if ({1'b0, bis_reg} + 13'd1 >= n_eff)
                begin
                    bis_reg <= '0;
                    sector_reg <= sector_next;
                end
                else
                begin
                    bis_reg <= bis_reg + 12'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_block)
        begin
            cipher_reg <= {in_item.cipher_high, in_item.cipher_low};
        end
        if (cmd.dkey_init)
        begin
            dkey_last_reg <= dkey_reg;
            rnd_reg <= 4'd1;
        end
        if (cmd.dkey_step)
        begin
            dkey_last_reg <= key_step(dkey_last_reg, rnd_reg);
            rnd_reg <= rnd_reg + 4'd1;
        end
        if (cmd.tweak_init)
        begin
            st_reg <= sector_reg ^ tkey_reg;
            rk_reg <= tkey_reg;
            rnd_reg <= 4'd1;
        end
        if (cmd.tweak_round)
        begin
            st_reg <= enc_round(st_reg, rnd_reg == AES_ROUNDS[ROUND_W-1:0])
                      ^ key_step(rk_reg, rnd_reg);
            rk_reg <= key_step(rk_reg, rnd_reg);
            rnd_reg <= rnd_reg + 4'd1;
        end
        if (cmd.data_init)
        begin
            st_reg <= cipher_reg ^ tweak_reg ^ dkey_last_reg;
            rk_reg <= key_unstep(dkey_last_reg, AES_ROUNDS[ROUND_W-1:0]);
            rnd_reg <= AES_ROUNDS[ROUND_W-1:0] - 4'd1;
        end
        if (cmd.data_round)
        begin
            st_reg <= (rnd_reg == '0) ? dec_tmp : inv_mix(dec_tmp);
            if (rnd_reg != '0)
            begin
                rk_reg <= key_unstep(rk_reg, rnd_reg);
                rnd_reg <= rnd_reg - 4'd1;
            end
        end
        if (cmd.finish)
        begin
            plain_reg <= st_reg ^ tweak_reg;
        end
    end

endmodule
`default_nettype wire

### src/aes_xts_sector_decrypt_core.sv
`default_nettype none
// channel | direction | handshake              | payload
// in      | input     | in_valid / in_ready    | in_data (restart, cipher)
// out     | output    | out_valid / out_ready  | out_data (plain)
// cfg     | input     | cfg_we                 | cfg_index, cfg_data
// At a sector start the tweak is encrypted before the block; after a data key write the
// last round key is rebuilt first. One AES round per cycle on a shared state register.
// The next input is taken in the same cycle the result is presented, not before.
// Reset clears keys, sector and tweak; blocks per sector resets to 32.
// A result still held at out stalls the next block in its last step until out transfers.
module aes_xts_sector_decrypt_core
(
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              in_valid,
    output logic                             in_ready,
    input  axsd_pkg::in_item_t               in_data,
    output logic                             out_valid,
    input  wire                              out_ready,
    output axsd_pkg::out_item_t              out_data,
    input  wire                              cfg_we,
    input  wire [axsd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire [axsd_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import axsd_pkg::*;

    axsd_cmd_t  cmd;
    axsd_stat_t stat;

    axsd_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    axsd_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_item   (in_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_item  (out_data)
    );

    ap_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.tweak_round || cmd.data_round) |-> !in_ready)
        else $error("input ready during rounds");
    ap_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> out_valid)
        else $error("result not presented");
    ap_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cmd))
        else $error("conflicting commands");

endmodule
`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 100ps
`default_nettype none
module testbench;
    import axsd_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    in_item_t in_data;
    logic out_valid;
    logic out_ready;
    out_item_t out_data;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    aes_xts_sector_decrypt_core u_dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // shadow configuration and sector state
    logic [127:0] data_key;
    logic [127:0] tweak_key;
    logic [127:0] start_sector;
    logic [12:0] sector_blocks;
    logic [127:0] tweak_now;
    logic [127:0] sector_now;
    int unsigned block_idx;

    in_item_t cipher_queue[$];
    out_item_t plain_queue[$];
    int unsigned gap_left;
    int unsigned stall_left;
    int unsigned idle_cycles;
    int unsigned errors;
    int unsigned blocks_sent;
    int unsigned blocks_checked;
    int unsigned restarts_sent;
    bit feeding_done;

    function automatic logic [7:0] sbox_inverse(input logic [7:0] v);
        logic [7:0] r;
        r = 8'h00;
        for (int i = 0; i < 256; i++)
        begin
            if (SBOX[i] == v)
            begin
                r = i[7:0];
            end
        end
        return r;
    endfunction

    function automatic logic [7:0] mul2(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        logic [7:0] x;
        p = 8'h00;
        x = a;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
            begin
                p ^= x;
            end
            x = mul2(x);
        end
        return p;
    endfunction

    function automatic void expand_schedule(input logic [127:0] key, output logic [127:0] rk [11]);
        logic [31:0] w [44];
        logic [31:0] t;
        for (int i = 0; i < 4; i++)
        begin
            w[i] = key[127 - 32*i -: 32];
        end
        for (int i = 4; i < 44; i++)
        begin
            t = w[i-1];
            if ((i % 4) == 0)
            begin
                t = {SBOX[t[23:16]] ^ RCON[i/4 - 1], SBOX[t[15:8]], SBOX[t[7:0]],
                     SBOX[t[31:24]]};
            end
            w[i] = w[i-4] ^ t;
        end
        for (int r = 0; r < 11; r++)
        begin
            rk[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
        end
    endfunction

    function automatic logic [127:0] aes_forward(input logic [127:0] blk, input logic [127:0] key);
        logic [127:0] rk [11];
        logic [7:0] s [16];
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3, al;
        logic [127:0] o;
        expand_schedule(key, rk);
        for (int i = 0; i < 16; i++)
        begin
            s[i] = blk[127 - 8*i -: 8] ^ rk[0][127 - 8*i -: 8];
        end
        for (int r = 1; r <= 10; r++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                for (int i = 0; i < 4; i++)
                begin
                    t[i + 4*c] = SBOX[s[i + 4*((c + i) % 4)]];
                end
            end
            if (r != 10)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
                    al = a0 ^ a1 ^ a2 ^ a3;
                    t[4*c]   = a0 ^ al ^ mul2(a0 ^ a1);
                    t[4*c+1] = a1 ^ al ^ mul2(a1 ^ a2);
                    t[4*c+2] = a2 ^ al ^ mul2(a2 ^ a3);
                    t[4*c+3] = a3 ^ al ^ mul2(a3 ^ a0);
                end
            end
            for (int i = 0; i < 16; i++)
            begin
                s[i] = t[i] ^ rk[r][127 - 8*i -: 8];
            end
        end
        for (int i = 0; i < 16; i++)
        begin
            o[127 - 8*i -: 8] = s[i];
        end
        return o;
    endfunction

    function automatic logic [127:0] aes_inverse(input logic [127:0] blk, input logic [127:0] key);
        logic [127:0] rk [11];
        logic [7:0] s [16];
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3;
        logic [127:0] o;
        expand_schedule(key, rk);
        for (int i = 0; i < 16; i++)
        begin
            s[i] = blk[127 - 8*i -: 8] ^ rk[10][127 - 8*i -: 8];
        end
        for (int r = 9; r >= 0; r--)
        begin
            for (int c = 0; c < 4; c++)
            begin
                for (int i = 0; i < 4; i++)
                begin
                    t[i + 4*c] = sbox_inverse(s[i + 4*((c - i + 4) % 4)]);
                end
            end
            for (int i = 0; i < 16; i++)
            begin
                s[i] = t[i] ^ rk[r][127 - 8*i -: 8];
            end
            if (r != 0)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
                    s[4*c]   = gf_mul(a0, 14) ^ gf_mul(a1, 11) ^ gf_mul(a2, 13) ^ gf_mul(a3, 9);
                    s[4*c+1] = gf_mul(a0, 9) ^ gf_mul(a1, 14) ^ gf_mul(a2, 11) ^ gf_mul(a3, 13);
                    s[4*c+2] = gf_mul(a0, 13) ^ gf_mul(a1, 9) ^ gf_mul(a2, 14) ^ gf_mul(a3, 11);
                    s[4*c+3] = gf_mul(a0, 11) ^ gf_mul(a1, 13) ^ gf_mul(a2, 9) ^ gf_mul(a3, 14);
                end
            end
        end
        for (int i = 0; i < 16; i++)
        begin
            o[127 - 8*i -: 8] = s[i];
        end
        return o;
    endfunction

    function automatic logic [127:0] tweak_times_x(input logic [127:0] tw);
        logic [7:0] b [16];
        logic [127:0] o;
        logic carry;
        for (int i = 0; i < 16; i++)
        begin
            b[i] = tw[127 - 8*i -: 8];
        end
        carry = b[15][7];
        for (int i = 15; i > 0; i--)
        begin
            b[i] = {b[i][6:0], b[i-1][7]};
        end
        b[0] = {b[0][6:0], 1'b0} ^ (carry ? 8'h87 : 8'h00);
        for (int i = 0; i < 16; i++)
        begin
            o[127 - 8*i -: 8] = b[i];
        end
        return o;
    endfunction

    function automatic void predict_plain(input in_item_t item);
        int unsigned limit;
        logic [127:0] blk;
        out_item_t res;
        limit = 32'(sector_blocks);
        if (limit == 0)
        begin
            limit = 1;
        end
        if (limit > MAX_SECTOR_BLOCKS)
        begin
            limit = MAX_SECTOR_BLOCKS;
        end
        if (item.restart)
        begin
            sector_now = start_sector;
            block_idx = 0;
        end
        if (block_idx == 0)
        begin
            tweak_now = aes_forward(sector_now, tweak_key);
        end
        blk = {item.cipher_high, item.cipher_low} ^ tweak_now;
        blk = aes_inverse(blk, data_key) ^ tweak_now;
        res.plain_high = blk[127:64];
        res.plain_low = blk[63:0];
        plain_queue.push_back(res);
        tweak_now = tweak_times_x(tweak_now);
        if (block_idx + 1 >= limit)
        begin
            block_idx = 0;
            sector_now = sector_now + 128'd1;
        end
        else
        begin
            block_idx++;
        end
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_DATA_KEY_HIGH: data_key[127:64] = value;
            REG_DATA_KEY_LOW: data_key[63:0] = value;
            REG_TWEAK_KEY_HIGH: tweak_key[127:64] = value;
            REG_TWEAK_KEY_LOW: tweak_key[63:0] = value;
            REG_START_SECTOR_HIGH: start_sector[127:64] = value;
            REG_START_SECTOR_LOW: start_sector[63:0] = value;
            REG_BLOCKS_PER_SECTOR: sector_blocks = value[12:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic drain_and_settle();
        while (cipher_queue.size() != 0 || in_valid || plain_queue.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (40) @(posedge clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic int unsigned pick_gap();
        if ($urandom_range(0, 9) < 6)
        begin
            return 0;
        end
        if ($urandom_range(0, 9) < 8)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    task automatic queue_blocks(input int unsigned count, input bit first_restart);
        in_item_t item;
        for (int i = 0; i < count; i++)
        begin
            item.restart = (i == 0) ? first_restart : ($urandom_range(0, 29) == 0);
            item.cipher_high = rand64();
            item.cipher_low = rand64();
            cipher_queue.push_back(item);
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data <= '0;
            gap_left <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                predict_plain(in_data);
                blocks_sent++;
                if (in_data.restart)
                begin
                    restarts_sent++;
                end
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left != 0)
                begin
                    in_valid <= 1'b0;
                    gap_left <= gap_left - 1;
                end
                else if (cipher_queue.size() != 0)
                begin
                    in_valid <= 1'b1;
                    in_data <= cipher_queue.pop_front();
                    gap_left <= pick_gap();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_left <= 0;
            idle_cycles <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (plain_queue.size() == 0)
                begin
                    $display("%0t: unexpected transfer %h", $time, out_data);
                    errors++;
                end
                else
                begin
                    if (out_data.plain_high !== plain_queue[0].plain_high)
                    begin
                        $display("%0t: plain_high expected %h actual %h", $time,
                                 plain_queue[0].plain_high, out_data.plain_high);
                        errors++;
                    end
                    if (out_data.plain_low !== plain_queue[0].plain_low)
                    begin
                        $display("%0t: plain_low expected %h actual %h", $time,
                                 plain_queue[0].plain_low, out_data.plain_low);
                        errors++;
                    end
                    void'(plain_queue.pop_front());
                    blocks_checked++;
                end
            end
            if (stall_left != 0)
            begin
                out_ready <= 1'b0;
                stall_left <= stall_left - 1;
            end
            else
            begin
                out_ready <= 1'b1;
                stall_left <= pick_gap();
            end
            if ((in_valid && in_ready) || (out_valid && out_ready) ||
                (cipher_queue.size() == 0 && !in_valid && plain_queue.size() == 0))
            begin
                idle_cycles <= 0;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
                if (idle_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("CHECK FAILED");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        in_item_t item;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        data_key = '0;
        tweak_key = '0;
        start_sector = '0;
        sector_blocks = 13'd32;
        tweak_now = '0;
        sector_now = '0;
        block_idx = 0;
        errors = 0;
        blocks_sent = 0;
        blocks_checked = 0;
        restarts_sent = 0;
        feeding_done = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset keys, no restart: sector 0; extreme cipher values
        item = '0;
        cipher_queue.push_back(item);
        item.cipher_high = '1;
        item.cipher_low = '1;
        cipher_queue.push_back(item);
        item.cipher_high = 64'h8000_0000_0000_0001;
        item.cipher_low = 64'h0123_4567_89ab_cdef;
        cipher_queue.push_back(item);
        drain_and_settle();

        // sector wrap at 2^128 with one-block sectors
        write_reg(REG_DATA_KEY_HIGH, '1);
        write_reg(REG_DATA_KEY_LOW, '1);
        write_reg(REG_TWEAK_KEY_HIGH, 64'h0001_0203_0405_0607);
        write_reg(REG_TWEAK_KEY_LOW, 64'h0809_0a0b_0c0d_0e0f);
        write_reg(REG_START_SECTOR_HIGH, '1);
        write_reg(REG_START_SECTOR_LOW, 64'hffff_ffff_ffff_fffe);
        write_reg(REG_BLOCKS_PER_SECTOR, 64'd1);
        queue_blocks(4, 1'b1);
        drain_and_settle();

        // zero size, low carry into high word, restart mid-sector
        write_reg(REG_START_SECTOR_HIGH, 64'h0);
        write_reg(REG_START_SECTOR_LOW, '1);
        write_reg(REG_BLOCKS_PER_SECTOR, 64'd0);
        queue_blocks(3, 1'b1);
        drain_and_settle();
        write_reg(REG_BLOCKS_PER_SECTOR, 64'd3);
        queue_blocks(2, 1'b1);
        item.restart = 1'b1;
        item.cipher_high = rand64();
        item.cipher_low = rand64();
        cipher_queue.push_back(item);
        queue_blocks(3, 1'b0);
        drain_and_settle();

        // oversized and maximum sector sizes
        write_reg(REG_BLOCKS_PER_SECTOR, 64'h1fff);
        queue_blocks(4, 1'b1);
        drain_and_settle();
        write_reg(REG_BLOCKS_PER_SECTOR, 64'd4096);
        write_reg(REG_UNUSED, rand64());
        queue_blocks(3, 1'b1);
        drain_and_settle();

        // random phases, mid-sector changes of key, size and start sector
        while (blocks_sent < 750)
        begin
            case ($urandom_range(0, 5))
                0: write_reg(REG_DATA_KEY_HIGH, rand64());
                1: write_reg(REG_DATA_KEY_LOW, rand64());
                2: write_reg(REG_TWEAK_KEY_HIGH, rand64());
                3: write_reg(REG_TWEAK_KEY_LOW, rand64());
                4: write_reg(REG_START_SECTOR_LOW, rand64());
                default: write_reg(REG_START_SECTOR_HIGH, rand64());
            endcase
            if ($urandom_range(0, 1) == 0)
            begin
                write_reg(REG_BLOCKS_PER_SECTOR, 64'($urandom_range(1, 8)));
            end
            else if ($urandom_range(0, 7) == 0)
            begin
                write_reg(REG_BLOCKS_PER_SECTOR, 64'($urandom_range(0, 8191)));
            end
            else
            begin
                write_reg(REG_BLOCKS_PER_SECTOR, 64'($urandom_range(9, 40)));
            end
            queue_blocks($urandom_range(10, 60), $urandom_range(0, 3) != 0);
            drain_and_settle();
        end

        $display("Decrypted %0d blocks, %0d restarts; %0d results checked.",
                 blocks_sent, restarts_sent, blocks_checked);
        $display("Covered key changes, sector wrap, zero/oversize sector sizes.");
        if (errors == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire

### filelist.f
src/axsd_pkg.sv
src/axsd_ctrl.sv
src/axsd_dp.sv
src/aes_xts_sector_decrypt_core.sv
tb/testbench.sv
